### hw/rtl/dlr_pkg.sv
// Shared constants for the DDA line rasterizer: default widths and item kind codes.
// No dependencies; imported by dlr_divider and dda_line_rasterizer_unit.
`timescale 1ns / 1ps
`default_nettype none

package dlr_pkg;

   // Default coordinate and fraction widths.
   localparam int COORD_BITS_DEF = 11;
   localparam int FRAC_BITS_DEF  = 16;

   // Width of each coordinate field on the stream ports.
   localparam int FIELD_BITS = 11;

   // Item kind codes carried in the request tuser.
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

endpackage : dlr_pkg

`default_nettype wire

### hw/rtl/dlr_divider.sv
// Restoring divider that turns a line's axis delta into a signed fixed-point increment.
// One compare and subtract per cycle; uses dlr_pkg for its default widths.
`timescale 1ns / 1ps
`default_nettype none

module dlr_divider #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          negate,
   input  wire logic [COORD_BITS-1:0]         dividend,
   input  wire logic [COORD_BITS-1:0]         divisor,
   output logic                               done,
   output logic signed [FRAC_BITS+1:0]        step
);
   import dlr_pkg::*;

   // One integer bit, FRAC_BITS fraction bits and one guard bit for rounding.
   localparam int QUOT_BITS = FRAC_BITS + 2;
   localparam int LAST_ITER = QUOT_BITS - 1;
   localparam int CNT_BITS  = $clog2(QUOT_BITS);

   logic [COORD_BITS:0]   rem_ff, rem_in;
   logic [QUOT_BITS-1:0]  quot_ff, quot_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [COORD_BITS-1:0] divisor_ff, divisor_in;
   logic                  negate_ff, negate_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [COORD_BITS:0]   diff;
   logic                  fits;
   logic [COORD_BITS-1:0] kept;
   logic [FRAC_BITS:0]    rounded;
   logic signed [FRAC_BITS+1:0] mag;

   // Shared compare and subtract: the remainder always stays below twice the divisor.
   assign diff = rem_ff - {1'b0, divisor_ff};
   assign fits = (rem_ff >= {1'b0, divisor_ff});
   assign kept = fits ? diff[COORD_BITS-1:0] : rem_ff[COORD_BITS-1:0];

   // Sequencing of the iterations.
   always_comb begin
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      count_in   = count_ff;
      divisor_in = divisor_ff;
      negate_in  = negate_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = {1'b0, dividend};
         quot_in    = '0;
         count_in   = '0;
         divisor_in = divisor;
         negate_in  = negate;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in   = {kept, 1'b0};
         quot_in  = {quot_ff[QUOT_BITS-2:0], fits};
         count_in = count_ff + CNT_BITS'(1);
         if (count_ff == CNT_BITS'(LAST_ITER)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      count_ff   <= count_in;
      divisor_ff <= divisor_in;
      negate_ff  <= negate_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Round to nearest on the guard bit, then apply the sign of the delta.
   assign rounded = quot_ff[QUOT_BITS-1:1] + (FRAC_BITS+1)'(quot_ff[0]);
   assign mag     = $signed({1'b0, rounded});
   assign step    = negate_ff ? -mag : mag;
   assign done    = done_ff;

endmodule : dlr_divider

`default_nettype wire

### hw/rtl/dda_line_rasterizer_unit.sv
// Top level of the DDA line rasterizer: item sequencer, accumulators and result register.
// Depends on dlr_pkg and dlr_divider.
//
// Usage: each request transfer carries one item. tuser gives its kind: a start item
// brings both endpoints in tdata, an advance item asks for the next pixel of the line.
// Every item yields exactly one response transfer holding the pixel coordinates, a
// valid flag in tuser (low for an advance with no line active) and tlast on the end
// pixel of the line.
// A start item has its two increments worked out one after the other on a single
// restoring divider, one quotient bit per cycle with FRAC_BITS + 2 bits each. A start
// with equal endpoints, and every advance item, skips the divider: the accumulator
// update in the accept cycle, then the rounding into the response register once that
// register is free. The request side is ready again as soon as the result sits in the
// response register.
// Reset clears the sequencer, the active line and the response valid; no line is active
// afterwards. If the receiver stalls, the pending response holds in its register, one
// further item is accepted and worked on, and the block waits with its result until
// the response register is free.
`timescale 1ns / 1ps
`default_nettype none

module dda_line_rasterizer_unit #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request: start_x, start_y, end_x, end_y, then zero fill.
   input  wire logic [4*dlr_pkg::FIELD_BITS+3:0] req_tdata,
   // Request: kind.
   input  wire logic [0:0]                       req_tuser,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // Response: pixel_x, pixel_y, then zero fill.
   output logic [2*dlr_pkg::FIELD_BITS+1:0]      rsp_tdata,
   // Response: pixel_valid.
   output logic [0:0]                            rsp_tuser,
   // Response: last_pixel.
   output logic                                  rsp_tlast,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready
);
   import dlr_pkg::*;

   localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 2;
   localparam int STEP_BITS = FRAC_BITS + 2;
   localparam int PIX_BITS  = ACC_BITS - FRAC_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIVX = 2'd1;
   localparam logic [1:0] ST_DIVY = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic signed [ACC_BITS-1:0]   x_accum_ff, x_accum_in;
   logic signed [ACC_BITS-1:0]   y_accum_ff, y_accum_in;
   logic signed [STEP_BITS-1:0]  x_step_ff, x_step_in;
   logic signed [STEP_BITS-1:0]  y_step_ff, y_step_in;
   logic [COORD_BITS-1:0]        steps_left_ff, steps_left_in;
   logic                         line_active_ff, line_active_in;
   logic                         emit_valid_ff, emit_valid_in;
   logic [COORD_BITS-1:0]        ady_ff, ady_in;
   logic                         y_neg_ff, y_neg_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0]        pixel_x_ff, pixel_x_in;
   logic [FIELD_BITS-1:0]        pixel_y_ff, pixel_y_in;
   logic                         pixel_valid_ff, pixel_valid_in;
   logic                         last_pixel_ff, last_pixel_in;

   logic                         accept;
   logic                         is_advance;
   logic [COORD_BITS-1:0]        sx, sy, ex, ey;
   logic signed [COORD_BITS:0]   dx, dy, ndx, ndy;
   logic [COORD_BITS-1:0]        adx, ady;
   logic [COORD_BITS-1:0]        steps;
   logic [COORD_BITS-1:0]        steps_dec;
   logic                         slot_free;

   logic                         div_start;
   logic                         div_negate;
   logic [COORD_BITS-1:0]        div_dividend;
   logic [COORD_BITS-1:0]        div_divisor;
   logic                         div_done;
   logic signed [STEP_BITS-1:0]  div_step;

   // Rounds an accumulator to the nearest pixel and saturates it to the coordinate range.
   function automatic logic [COORD_BITS-1:0] to_pixel(input logic signed [ACC_BITS-1:0] acc);
      logic signed [ACC_BITS-1:0] biased;
      logic [PIX_BITS-1:0]        whole;
      logic [COORD_BITS-1:0]      pix;
      biased = acc + $signed(ACC_BITS'(1) << (FRAC_BITS - 1));
      whole  = biased[ACC_BITS-1:FRAC_BITS];
      if (biased[ACC_BITS-1]) begin
         pix = '0;
      end else if (whole[PIX_BITS-1:COORD_BITS] != '0) begin
         pix = '1;
      end else begin
         pix = whole[COORD_BITS-1:0];
      end
      return pix;
   endfunction

   // Request decode: deltas, their magnitudes and the major-axis step count.
   assign accept     = req_tvalid && req_tready;
   assign is_advance = (req_tuser[0] == KIND_ADVANCE);
   assign sx  = COORD_BITS'(req_tdata[FIELD_BITS-1:0]);
   assign sy  = COORD_BITS'(req_tdata[2*FIELD_BITS-1:FIELD_BITS]);
   assign ex  = COORD_BITS'(req_tdata[3*FIELD_BITS-1:2*FIELD_BITS]);
   assign ey  = COORD_BITS'(req_tdata[4*FIELD_BITS-1:3*FIELD_BITS]);
   assign dx  = $signed({1'b0, ex}) - $signed({1'b0, sx});
   assign dy  = $signed({1'b0, ey}) - $signed({1'b0, sy});
   assign ndx = -dx;
   assign ndy = -dy;
   assign adx = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
   assign ady = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
   assign steps     = (adx > ady) ? adx : ady;
   assign steps_dec = steps_left_ff - COORD_BITS'(1);
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // The x increment starts at acceptance, the y increment when the x one is done.
   always_comb begin
      div_start    = 1'b0;
      div_negate   = dx[COORD_BITS];
      div_dividend = adx;
      div_divisor  = steps;
      if (state_ff == ST_DIVX) begin
         div_start    = div_done;
         div_negate   = y_neg_ff;
         div_dividend = ady_ff;
         div_divisor  = steps_left_ff;
      end else if (state_ff == ST_IDLE) begin
         div_start = accept && !is_advance && (steps != '0);
      end
   end

   dlr_divider #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .negate   (div_negate),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .step     (div_step)
   );

   // Item sequencer and line state.
   always_comb begin
      state_in       = state_ff;
      x_accum_in     = x_accum_ff;
      y_accum_in     = y_accum_ff;
      x_step_in      = x_step_ff;
      y_step_in      = y_step_ff;
      steps_left_in  = steps_left_ff;
      line_active_in = line_active_ff;
      emit_valid_in  = emit_valid_ff;
      ady_in         = ady_ff;
      y_neg_in       = y_neg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      pixel_x_in     = pixel_x_ff;
      pixel_y_in     = pixel_y_ff;
      pixel_valid_in = pixel_valid_ff;
      last_pixel_in  = last_pixel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EMIT;
               if (is_advance) begin
                  emit_valid_in = line_active_ff;
                  if (line_active_ff) begin
                     x_accum_in = x_accum_ff +
                        {{(ACC_BITS-STEP_BITS){x_step_ff[STEP_BITS-1]}}, x_step_ff};
                     y_accum_in = y_accum_ff +
                        {{(ACC_BITS-STEP_BITS){y_step_ff[STEP_BITS-1]}}, y_step_ff};
                     steps_left_in  = steps_dec;
                     line_active_in = (steps_dec != '0);
                  end
               end else begin
                  emit_valid_in  = 1'b1;
                  x_accum_in     = $signed({2'b00, sx, {FRAC_BITS{1'b0}}});
                  y_accum_in     = $signed({2'b00, sy, {FRAC_BITS{1'b0}}});
                  steps_left_in  = steps;
                  ady_in         = ady;
                  y_neg_in       = dy[COORD_BITS];
                  x_step_in      = '0;
                  y_step_in      = '0;
                  line_active_in = (steps != '0);
                  if (steps != '0) begin
                     state_in = ST_DIVX;
                  end
               end
            end
         end
         ST_DIVX: begin
            if (div_done) begin
               x_step_in = div_step;
               state_in  = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_done) begin
               y_step_in = div_step;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Load the response register once the previous transfer has gone.
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               pixel_valid_in = emit_valid_ff;
               last_pixel_in  = emit_valid_ff && !line_active_ff;
               pixel_x_in     = emit_valid_ff ? FIELD_BITS'(to_pixel(x_accum_ff)) : '0;
               pixel_y_in     = emit_valid_ff ? FIELD_BITS'(to_pixel(y_accum_ff)) : '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_accum_ff     <= x_accum_in;
      y_accum_ff     <= y_accum_in;
      x_step_ff      <= x_step_in;
      y_step_ff      <= y_step_in;
      steps_left_ff  <= steps_left_in;
      emit_valid_ff  <= emit_valid_in;
      ady_ff         <= ady_in;
      y_neg_ff       <= y_neg_in;
      pixel_x_ff     <= pixel_x_in;
      pixel_y_ff     <= pixel_y_in;
      pixel_valid_ff <= pixel_valid_in;
      last_pixel_ff  <= last_pixel_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Port drive.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, pixel_y_ff, pixel_x_ff};
   assign rsp_tuser  = pixel_valid_ff;
   assign rsp_tlast  = last_pixel_ff;

endmodule : dda_line_rasterizer_unit

`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench for dda_line_rasterizer_unit: directed lines, then random lines.
// Uses dlr_pkg for widths and kind codes; a scoreboard class predicts every pixel.
`timescale 1ns / 1ps

module tb_top;

   localparam int COORD_BITS = dlr_pkg::COORD_BITS_DEF;
   localparam int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF;
   localparam int FIELD_BITS = dlr_pkg::FIELD_BITS;
   localparam int FIELD_MAX  = (1 << FIELD_BITS) - 1;
   localparam longint COORD_MAX = (longint'(1) << COORD_BITS) - 1;

   localparam int RANDOM_ITEMS  = 1725;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 2 * FRAC_BITS + 20;
   localparam int HOLD_PERIOD   = 3000;
   localparam int HOLD_OFFSET   = 800;
   localparam int HOLD_LENGTH   = 250;

   typedef struct packed {
      logic [FIELD_BITS-1:0] px;
      logic [FIELD_BITS-1:0] py;
      logic                  valid;
      logic                  last;
   } pixel_type;

   // Predicts the pixel for every accepted item and compares the pixels that come out.
   class pixel_scoreboard;
      pixel_type   pixel_queue[$];
      longint      x_acc, y_acc, x_inc, y_inc, steps_left;
      bit          line_on;
      int unsigned mismatches;
      int unsigned checked;

      function longint coord(logic [FIELD_BITS-1:0] v);
         return longint'(v) & COORD_MAX;
      endfunction

      function longint magnitude(longint v);
         return v < 0 ? -v : v;
      endfunction

      // Signed increment d / span in fixed point, rounded to nearest, ties away from zero.
      function longint fixed_step(longint d, longint span);
         longint mag, q;
         mag = magnitude(d) << FRAC_BITS;
         q   = (mag * 2 + span) / (2 * span);
         return d < 0 ? -q : q;
      endfunction

      // Round an accumulator to the nearest pixel and saturate into the coordinate range.
      function logic [FIELD_BITS-1:0] round_pixel(longint acc);
         longint r;
         r = acc + (longint'(1) << (FRAC_BITS - 1));
         if (r < 0)
            return '0;
         r = r >>> FRAC_BITS;
         if (r > COORD_MAX)
            r = COORD_MAX;
         return r[FIELD_BITS-1:0];
      endfunction

      function int pending();
         return pixel_queue.size();
      endfunction

      function void note_item(logic kind, logic [FIELD_BITS-1:0] sx, sy, ex, ey);
         longint dx, dy, span;
         pixel_type pix;
         pix = '0;
         if (kind == dlr_pkg::KIND_START) begin
            x_acc = coord(sx) << FRAC_BITS;
            y_acc = coord(sy) << FRAC_BITS;
            dx    = coord(ex) - coord(sx);
            dy    = coord(ey) - coord(sy);
            span  = magnitude(dx) > magnitude(dy) ? magnitude(dx) : magnitude(dy);
            if (span == 0) begin
               // A single point: no line remains active.
               x_inc      = 0;
               y_inc      = 0;
               steps_left = 0;
               line_on    = 1'b0;
            end else begin
               x_inc      = fixed_step(dx, span);
               y_inc      = fixed_step(dy, span);
               steps_left = span;
               line_on    = 1'b1;
            end
            pix.px    = round_pixel(x_acc);
            pix.py    = round_pixel(y_acc);
            pix.valid = 1'b1;
            pix.last  = !line_on;
         end else if (line_on) begin
            x_acc      += x_inc;
            y_acc      += y_inc;
            steps_left = (steps_left - 1) & COORD_MAX;
            if (steps_left == 0)
               line_on = 1'b0;
            pix.px    = round_pixel(x_acc);
            pix.py    = round_pixel(y_acc);
            pix.valid = 1'b1;
            pix.last  = !line_on;
         end
         // An advance with no active line leaves the pixel all zero.
         pixel_queue.push_back(pix);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch at %0t ns, pixel %0d: %s", $time, checked, what);
      endtask

      task check_pixel(logic [FIELD_BITS-1:0] px, py, logic valid, logic last);
         pixel_type want;
         if (pixel_queue.size() == 0) begin
            report_mismatch($sformatf("pixel (%0d,%0d) valid %b last %b with none outstanding",
                                      px, py, valid, last));
         end else begin
            want = pixel_queue.pop_front();
            if (px !== want.px)
               report_mismatch($sformatf("pixel_x %0d, predicted %0d", px, want.px));
            if (py !== want.py)
               report_mismatch($sformatf("pixel_y %0d, predicted %0d", py, want.py));
            if (valid !== want.valid)
               report_mismatch($sformatf("pixel_valid %b, predicted %b", valid, want.valid));
            if (last !== want.last)
               report_mismatch($sformatf("last_pixel %b, predicted %b", last, want.last));
         end
         checked++;
      endtask
   endclass

   logic                         clock;
   logic                         reset;
   logic [4*FIELD_BITS+3:0]      req_tdata;
   logic [0:0]                   req_tuser;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [2*FIELD_BITS+1:0]      rsp_tdata;
   logic [0:0]                   rsp_tuser;
   logic                         rsp_tlast;
   logic                         rsp_tvalid;
   logic                         rsp_tready;

   pixel_scoreboard sb = new;
   int              burst_left = 0;

   dda_line_rasterizer_unit #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),   // start_x, start_y, end_x, end_y, zero fill
      .req_tuser  (req_tuser),   // kind
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),   // pixel_x, pixel_y, zero fill
      .rsp_tuser  (rsp_tuser),   // pixel_valid
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Sender pacing: bursts of random length separated by random gaps.
   task automatic pace_sender();
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(13, 60)) @(posedge clock);
         else
            repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 20);
      end
   endtask

   // Offer one item and hold it until the transfer completes.
   task automatic offer(logic kind, logic [FIELD_BITS-1:0] sx, sy, ex, ey);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, ey, ex, sy, sx};
      do @(posedge clock); while (!req_tready);
      sb.note_item(kind, sx, sy, ex, ey);
      pace_sender();
   endtask

   // Advance items carry random endpoint fields, which the block must ignore.
   task automatic offer_advance();
      offer(dlr_pkg::KIND_ADVANCE,
            FIELD_BITS'($urandom_range(0, FIELD_MAX)), FIELD_BITS'($urandom_range(0, FIELD_MAX)),
            FIELD_BITS'($urandom_range(0, FIELD_MAX)), FIELD_BITS'($urandom_range(0, FIELD_MAX)));
   endtask

   task automatic run_line(logic [FIELD_BITS-1:0] sx, sy, ex, ey, int advances);
      offer(dlr_pkg::KIND_START, sx, sy, ex, ey);
      repeat (advances) offer_advance();
   endtask

   // Stop offering until every predicted pixel has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [FIELD_BITS-1:0] pick_end(logic [FIELD_BITS-1:0] from, int reach);
      int target;
      target = int'(from) + int'($urandom_range(0, 2 * reach)) - reach;
      if (target < 0)
         target = 0;
      if (target > FIELD_MAX)
         target = FIELD_MAX;
      return target[FIELD_BITS-1:0];
   endfunction

   // One random line: mostly short and run to its end, sometimes cut short or overrun.
   task automatic draw_random_line(output int sent);
      logic [FIELD_BITS-1:0] sx, sy, ex, ey;
      int reach, span, dxm, dym, advances, pick;
      sx    = FIELD_BITS'($urandom_range(0, FIELD_MAX));
      sy    = FIELD_BITS'($urandom_range(0, FIELD_MAX));
      pick  = $urandom_range(0, 19);
      reach = (pick == 0) ? FIELD_MAX : ((pick < 5) ? 120 : 16);
      ex    = pick_end(sx, reach);
      ey    = pick_end(sy, reach);
      dxm   = int'(ex) - int'(sx);
      dym   = int'(ey) - int'(sy);
      if (dxm < 0) dxm = -dxm;
      if (dym < 0) dym = -dym;
      span  = dxm > dym ? dxm : dym;
      pick  = $urandom_range(0, 9);
      if (span > 160)
         advances = $urandom_range(0, 30);
      else if (pick == 0)
         advances = $urandom_range(0, span);
      else if (pick == 1)
         advances = span + $urandom_range(1, 3);
      else
         advances = span;
      run_line(sx, sy, ex, ey, advances);
      sent = advances + 1;
   endtask

   // Main stimulus and end of run.
   initial begin : stimulus
      int items_sent;
      int sent;
      items_sent = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= dlr_pkg::KIND_START;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: advance with no line, single points at both extremes, full-range
      // diagonals with a restart mid-line, a steep line run past its end, a half-step tie.
      offer_advance();
      run_line(0, 0, 0, 0, 0);
      run_line(0, 0, FIELD_MAX, FIELD_MAX, 2);
      run_line(FIELD_MAX, 0, 0, FIELD_MAX, 2);
      run_line(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, 0);
      run_line(10, 20, 13, 10, 11);
      run_line(FIELD_MAX, 1000, FIELD_MAX - 2, 1001, 2);
      wait_for_results();

      // Random lines with some stray advances and an occasional full pause.
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 14) == 0)
            offer_advance();
         if ($urandom_range(0, 39) == 0)
            wait_for_results();
         draw_random_line(sent);
         items_sent += sent;
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Receiver: runs of always-ready, random and periodic stalls, with a long hold-off
   // now and then so that the block fills up and stalls its input.
   initial begin : receiver
      int unsigned cyc, hold_left, run_left, mode;
      cyc       = 0;
      hold_left = 0;
      run_left  = 0;
      mode      = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_left == 0 && (cyc % HOLD_PERIOD) == HOLD_OFFSET)
            hold_left = HOLD_LENGTH;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               mode     = $urandom_range(0, 2);
               run_left = $urandom_range(5, 80);
            end
            run_left--;
            case (mode)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_tready <= (cyc % 4) != 0;
               end
            endcase
         end
      end
   end

   // Check every response transfer against the oldest prediction.
   initial begin : monitor
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_pixel(rsp_tdata[FIELD_BITS-1:0], rsp_tdata[2*FIELD_BITS-1:FIELD_BITS],
                           rsp_tuser[0], rsp_tlast);
      end
   end

   // Watchdog: a run that takes far longer than the slowest correct one has hung.
   initial begin : watchdog
      int cycles_run;
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
